/* src/ppf_pkg.sv */
package ppf_pkg;

  localparam logic [2:0] MODE_GRAY     = 3'd0;
  localparam logic [2:0] MODE_INVERT   = 3'd1;
  localparam logic [2:0] MODE_BRIGHT   = 3'd2;
  localparam logic [2:0] MODE_SEPIA    = 3'd3;
  localparam logic [2:0] MODE_THRESH   = 3'd4;
  localparam logic [2:0] MODE_CONTRAST = 3'd5;
  localparam logic [2:0] MODE_PASS     = 3'd6;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_PARAM = 1'b1;

  // x/3 = (x*683)>>11, exact for x < 2048
  localparam logic [10:0] GRAY_RECIP = 11'd683;
  localparam int          GRAY_SHIFT = 11;
  // x/1000 = (x*268436)>>28, exact for x < 493448
  localparam logic [18:0] SEPIA_RECIP = 19'd268436;
  localparam int          SEPIA_SHIFT = 28;

  localparam int REM_W = 25;
  localparam int QUO_W = 9;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [8:0] param;
    logic [17:0]       num;
    logic [16:0]       den;
  } ppf_cfg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } ppf_div_t;

endpackage

/* src/ppf_cfg.sv */
module ppf_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [8:0]          cfg_data_i,
  output ppf_pkg::ppf_cfg_t   cfg_o
);

  logic [2:0]        mode_q;
  logic signed [8:0] param_q;
  logic [17:0]       num_q, num_d;
  logic [16:0]       den_q, den_d;
  logic signed [8:0] amt;
  logic [8:0]        amt_lo;
  logic [9:0]        amt_hi;

  // contrast amount saturates at -255 so the numerator factor stays non-negative
  always_comb begin
    amt    = (cfg_data_i == 9'h100) ? -9'sd255 : $signed(cfg_data_i);
    amt_lo = 9'(10'($signed(amt)) + 10'sd255);
    amt_hi = 10'(10'sd259 - 10'($signed(amt)));
    num_d  = 18'(amt_lo * 9'd259);
    den_d  = 17'(amt_hi * 8'd255);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ppf_pkg::MODE_PASS;
      param_q <= '0;
      num_q   <= 18'd66045;
      den_q   <= 17'd66045;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ppf_pkg::REG_MODE) begin
        mode_q <= cfg_data_i[2:0];
      end else begin
        param_q <= $signed(cfg_data_i);
        num_q   <= num_d;
        den_q   <= den_d;
      end
    end
  end

  assign cfg_o = '{mode: mode_q, param: param_q, num: num_q, den: den_q};

endmodule

/* src/ppf_div_step.sv */
module ppf_div_step (
  input  ppf_pkg::ppf_div_t div_i,
  output ppf_pkg::ppf_div_t div_o
);

  // three restoring quotient bits
  always_comb begin
    div_o = div_i;
    for (int k = 0; k < 3; k++) begin
      if (div_o.rem >= div_o.dsh) begin
        div_o.rem = div_o.rem - div_o.dsh;
        div_o.quo = {div_o.quo[ppf_pkg::QUO_W-2:0], 1'b1};
      end else begin
        div_o.quo = {div_o.quo[ppf_pkg::QUO_W-2:0], 1'b0};
      end
      div_o.dsh = div_o.dsh >> 1;
    end
  end

endmodule

/* src/rgb_pixel_point_filter.sv */
// RGB pixel point filter.
// Input channel: valid_i / stall_o with red_in_i, green_in_i, blue_in_i and
// last_pixel_i; a transfer happens on a clock edge with valid_i high and
// stall_o low. Output channel: valid_o / stall_i with red_out_o, green_out_o,
// blue_out_o and last_out_o, same transfer rule.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 mode, 1 signed parameter). Write only while the pipeline is empty.
// Throughput is one pixel per clock while stall_i does not hold the output.
// There are four register stages (operand/product, reciprocal multiply
// plus three divider bits, three more divider bits, last three bits plus
// the output mux). The contrast divide is a 9-bit restoring divider
// spread over those stages.
// Reset clears all stage valids and sets mode to pass-through, parameter 0.
// When stall_i holds the output, the output register keeps its pixel and
// empty stages upstream still fill, so stall_o rises only once every stage
// holds a pixel.
module rgb_pixel_point_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [8:0] cfg_data_i,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic       last_pixel_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic       last_out_o
);

  ppf_pkg::ppf_cfg_t cfg;

  ppf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic va_q, vb_q, vc_q, vo_q;
  logic rdy_a, rdy_b, rdy_c, rdy_o;

  assign rdy_o   = !vo_q || !stall_i;
  assign rdy_c   = !vc_q || rdy_o;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign stall_o = !rdy_a;

  // ---------------- stage A: products and sums
  localparam int REM_W_L = ppf_pkg::REM_W;
  logic [7:0]        pin [3];
  logic [7:0]        pa_q [3];
  logic              la_q;
  logic [9:0]        gsum_a_q;
  logic [18:0]       sep_d [3];
  logic [18:0]       sep_a_q [3];
  logic [7:0]        brt_d [3];
  logic [7:0]        brt_a_q [3];
  logic [REM_W_L-1:0] prod_a_q [3];
  logic [REM_W_L-1:0] prod_d [3];
  logic              neg_a_q [3];
  logic              neg_d [3];

  assign pin[0] = red_in_i;
  assign pin[1] = green_in_i;
  assign pin[2] = blue_in_i;

  always_comb begin
    logic signed [9:0] sb;
    logic [7:0]        mag;
    sep_d[0] = 19'(19'd393 * red_in_i) + 19'(19'd769 * green_in_i)
             + 19'(19'd189 * blue_in_i);
    sep_d[1] = 19'(19'd349 * red_in_i) + 19'(19'd686 * green_in_i)
             + 19'(19'd168 * blue_in_i);
    sep_d[2] = 19'(19'd272 * red_in_i) + 19'(19'd534 * green_in_i)
             + 19'(19'd131 * blue_in_i);
    for (int i = 0; i < 3; i++) begin
      sb = $signed({2'b00, pin[i]}) + $signed({cfg.param[8], cfg.param});
      if (sb < 0) begin
        brt_d[i] = 8'd0;
      end else if (sb > 10'sd255) begin
        brt_d[i] = 8'd255;
      end else begin
        brt_d[i] = sb[7:0];
      end
      neg_d[i]  = !pin[i][7];
      mag       = pin[i][7] ? {1'b0, pin[i][6:0]} : 8'(9'd128 - {1'b0, pin[i]});
      prod_d[i] = REM_W_L'(cfg.num * mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      la_q     <= last_pixel_i;
      gsum_a_q <= 10'(red_in_i) + 10'(green_in_i) + 10'(blue_in_i);
      for (int i = 0; i < 3; i++) begin
        pa_q[i]     <= pin[i];
        sep_a_q[i]  <= sep_d[i];
        brt_a_q[i]  <= brt_d[i];
        prod_a_q[i] <= prod_d[i];
        neg_a_q[i]  <= neg_d[i];
      end
    end
  end

  // ---------------- stage B: reciprocal multiplies, divider bits 8..6
  ppf_pkg::ppf_div_t div_a [3];
  ppf_pkg::ppf_div_t div_b_d [3];
  ppf_pkg::ppf_div_t div_b_q [3];
  ppf_pkg::ppf_div_t div_c_d [3];
  ppf_pkg::ppf_div_t div_c_q [3];
  ppf_pkg::ppf_div_t div_o_d [3];
  logic [7:0]  pb_q [3];
  logic        lb_q;
  logic [7:0]  gray_b_q, gray_d;
  logic [7:0]  sep_b_q [3];
  logic [7:0]  sep_cl [3];
  logic [7:0]  brt_b_q [3];
  logic [20:0] gprod;
  logic [37:0] sprod [3];

  always_comb begin
    gprod  = 21'(gsum_a_q * ppf_pkg::GRAY_RECIP);
    gray_d = gprod[ppf_pkg::GRAY_SHIFT +: 8];
    for (int i = 0; i < 3; i++) begin
      sprod[i]  = 38'(sep_a_q[i] * ppf_pkg::SEPIA_RECIP);
      sep_cl[i] = (sprod[i][37:ppf_pkg::SEPIA_SHIFT] > 10'd255)
                ? 8'd255 : sprod[i][ppf_pkg::SEPIA_SHIFT +: 8];
      div_a[i].rem = prod_a_q[i];
      div_a[i].dsh = REM_W_L'({cfg.den, 8'd0});
      div_a[i].quo = '0;
      div_a[i].neg = neg_a_q[i];
      div_a[i].ovf = ({1'b0, prod_a_q[i]} >= {cfg.den, 9'd0});
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    ppf_div_step u_div_b (.div_i(div_a[i]),   .div_o(div_b_d[i]));
    ppf_div_step u_div_c (.div_i(div_b_q[i]), .div_o(div_c_d[i]));
    ppf_div_step u_div_o (.div_i(div_c_q[i]), .div_o(div_o_d[i]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      lb_q     <= la_q;
      gray_b_q <= gray_d;
      for (int i = 0; i < 3; i++) begin
        pb_q[i]    <= pa_q[i];
        sep_b_q[i] <= sep_cl[i];
        brt_b_q[i] <= brt_a_q[i];
        div_b_q[i] <= div_b_d[i];
      end
    end
  end

  // ---------------- stage C: threshold compare, divider bits 5..3
  logic [7:0] pc_q [3];
  logic       lc_q;
  logic [7:0] gray_c_q;
  logic       thr_c_q;
  logic [7:0] sep_c_q [3];
  logic [7:0] brt_c_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      lc_q     <= lb_q;
      gray_c_q <= gray_b_q;
      thr_c_q  <= ($signed({2'b00, gray_b_q}) >= $signed({cfg.param[8], cfg.param}));
      for (int i = 0; i < 3; i++) begin
        pc_q[i]    <= pb_q[i];
        sep_c_q[i] <= sep_b_q[i];
        brt_c_q[i] <= brt_b_q[i];
        div_c_q[i] <= div_c_d[i];
      end
    end
  end

  // ---------------- stage O: divider bits 2..0, mode select
  logic [7:0] res_d [3];
  logic [7:0] res_q [3];
  logic       lo_q;

  always_comb begin
    logic [7:0] con;
    for (int i = 0; i < 3; i++) begin
      if (!div_o_d[i].neg) begin
        con = (div_o_d[i].ovf || div_o_d[i].quo > 9'd127)
            ? 8'd255 : 8'(div_o_d[i].quo + 9'd128);
      end else begin
        con = (div_o_d[i].ovf || div_o_d[i].quo > 9'd128)
            ? 8'd0 : 8'(9'd128 - div_o_d[i].quo);
      end
      case (cfg.mode)
        ppf_pkg::MODE_GRAY:     res_d[i] = gray_c_q;
        ppf_pkg::MODE_INVERT:   res_d[i] = ~pc_q[i];
        ppf_pkg::MODE_BRIGHT:   res_d[i] = brt_c_q[i];
        ppf_pkg::MODE_SEPIA:    res_d[i] = sep_c_q[i];
        ppf_pkg::MODE_THRESH:   res_d[i] = thr_c_q ? 8'd255 : 8'd0;
        ppf_pkg::MODE_CONTRAST: res_d[i] = con;
        default:                res_d[i] = pc_q[i];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_o) begin
      vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vc_q) begin
      lo_q <= lc_q;
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

  assign valid_o     = vo_q;
  assign red_out_o   = res_q[0];
  assign green_out_o = res_q[1];
  assign blue_out_o  = res_q[2];
  assign last_out_o  = lo_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (va_q && vb_q && vc_q && vo_q && stall_i))
    else $error("input stalled while a stage is free");

  a_accept_fills_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> va_q)
    else $error("accepted pixel lost at first stage");

  a_held_output_keeps_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && stall_i && vc_q) |=> (vc_q && vo_q))
    else $error("pixel dropped behind a stalled output");

endmodule
